// ===== sv/audio_min_max_rms_summary_defines.svh =====
// Assertion macros for the audio min/max/RMS summary block.
// Included by the top-level RTL file, which carries the concurrent assertions.
`ifndef AUDIO_MIN_MAX_RMS_SUMMARY_DEFINES_SVH
`define AUDIO_MIN_MAX_RMS_SUMMARY_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define AMMRS_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define AMMRS_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/ammrs_pkg.sv =====
// Shared types and constants of the audio min/max/RMS summary block.
// Used by all modules of the block; depends on nothing.
package ammrs_pkg;

    localparam int FINE_WINDOW_DEF       = 256;
    localparam int COARSE_WINDOW_DEF     = 65536;
    localparam int MAX_BLOCK_SAMPLES_DEF = 1048576;
    localparam int SAMPLE_BITS_DEF       = 16;

    localparam int SAMPLE_W     = 16;
    localparam int SQ_W         = 31;
    localparam int FINE_SUM_W   = 41;
    localparam int COARSE_SUM_W = 55;
    localparam int BLOCK_SUM_W  = 51;
    localparam int FINE_CNT_W   = 11;
    localparam int COARSE_CNT_W = 15;
    localparam int BLOCK_CNT_W  = 21;
    localparam int DIVD_W       = 55;
    localparam int DIVS_W       = 21;
    localparam int DIV_CNT_W    = 6;
    localparam int RAD_W        = 42;
    localparam int ROOT_FULL_W  = 21;
    localparam int ROOT_W       = 16;
    localparam int ROOT_CNT_W   = 5;
    localparam int LEVEL_W      = 2;
    localparam int DATA_W       = 48;

    localparam logic [LEVEL_W-1:0] LEVEL_FINE   = 2'd0;
    localparam logic [LEVEL_W-1:0] LEVEL_COARSE = 2'd1;
    localparam logic [LEVEL_W-1:0] LEVEL_BLOCK  = 2'd2;

    typedef struct packed {
        logic busy;
        logic done;
    } unit_status_t;

    typedef struct packed {
        logic [LEVEL_W-1:0]         level;
        logic signed [SAMPLE_W-1:0] min_value;
        logic signed [SAMPLE_W-1:0] max_value;
        logic [ROOT_W-1:0]          rms_value;
        logic                       last_of_run;
    } result_t;

endpackage

// ===== sv/audio_min_max_rms_summary.sv =====
// Audio min/max/RMS summary over fine windows, coarse windows and the whole block.
// An ordinary sample goes through the accept, square and accumulate states before s_tready
// returns. Each result adds one pass through the shared divider (one quotient bit per
// cycle) and the shared root unit (one root bit per cycle), and a fine window end adds
// one more divider pass to scale its mean square for the coarse sum. Results wait in
// an output register; the sequencer stalls only when that register is still full.
// Depends on ammrs_pkg, ammrs_divider, ammrs_sqrt and ammrs_out_reg.
`include "audio_min_max_rms_summary_defines.svh"

module audio_min_max_rms_summary #(
    parameter int FINE_WINDOW       = ammrs_pkg::FINE_WINDOW_DEF,
    parameter int COARSE_WINDOW     = ammrs_pkg::COARSE_WINDOW_DEF,
    parameter int MAX_BLOCK_SAMPLES = ammrs_pkg::MAX_BLOCK_SAMPLES_DEF,
    parameter int SAMPLE_BITS       = ammrs_pkg::SAMPLE_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [ammrs_pkg::SAMPLE_W-1:0] s_tdata,  // sample
    input  logic                          s_tlast,  // block_end
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [ammrs_pkg::DATA_W-1:0]  m_tdata,  // min_value, max_value, rms_value
    output logic [ammrs_pkg::LEVEL_W-1:0] m_tuser,  // level
    output logic                          m_tlast   // last_of_run
);
    import ammrs_pkg::*;

    localparam int FINES_PER_COARSE = COARSE_WINDOW / FINE_WINDOW;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQUARE,
        ST_ACCUM,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_ROOT_START,
        ST_ROOT_WAIT,
        ST_EMIT,
        ST_SCALE_MUL,
        ST_SCALE_START,
        ST_SCALE_WAIT
    } state_t;

    state_t state_reg, state_next;

    logic signed [SAMPLE_W-1:0] x_reg, x_next;
    logic                       end_reg, end_next;
    logic                       close_coarse_reg, close_coarse_next;
    logic [LEVEL_W-1:0]         level_reg, level_next;
    logic [SQ_W-1:0]            sq_reg, sq_next;
    logic [ROOT_W-1:0]          rms_reg, rms_next;
    logic [DIVD_W-1:0]          prod_reg, prod_next;
    logic [DIVS_W-1:0]          m_reg, m_next;

    logic signed [SAMPLE_W-1:0] fine_min_reg, fine_min_next;
    logic signed [SAMPLE_W-1:0] fine_max_reg, fine_max_next;
    logic [FINE_SUM_W-1:0]      fine_sum_reg, fine_sum_next;
    logic [FINE_CNT_W-1:0]      fine_cnt_reg, fine_cnt_next;
    logic signed [SAMPLE_W-1:0] coarse_min_reg, coarse_min_next;
    logic signed [SAMPLE_W-1:0] coarse_max_reg, coarse_max_next;
    logic [COARSE_SUM_W-1:0]    coarse_sum_reg, coarse_sum_next;
    logic [COARSE_CNT_W-1:0]    coarse_cnt_reg, coarse_cnt_next;
    logic signed [SAMPLE_W-1:0] block_min_reg, block_min_next;
    logic signed [SAMPLE_W-1:0] block_max_reg, block_max_next;
    logic [BLOCK_SUM_W-1:0]     block_sum_reg, block_sum_next;
    logic [BLOCK_CNT_W-1:0]     block_cnt_reg, block_cnt_next;

    logic signed [SAMPLE_W-1:0]   x_in;
    logic signed [2*SAMPLE_W-1:0] square;
    logic [FINE_CNT_W-1:0]        fine_cnt_inc;
    logic [BLOCK_CNT_W-1:0]       block_cnt_inc;
    logic [COARSE_CNT_W-1:0]      coarse_cnt_inc;
    logic                         end_now;

    logic                  div_start;
    logic [DIVD_W-1:0]     div_dividend;
    logic [DIVS_W-1:0]     div_divisor;
    unit_status_t          div_stat;
    logic [DIVD_W-1:0]     div_quotient;
    logic                  root_start;
    unit_status_t          root_stat;
    logic [ROOT_W-1:0]     root_value;
    logic                  out_load;
    logic                  out_can_load;
    result_t               out_result;

    always_comb begin
        for (int i = 0; i < SAMPLE_W; i++) begin
            x_in[i] = (i < SAMPLE_BITS) ? s_tdata[i] : s_tdata[SAMPLE_BITS-1];
        end
    end

    assign square         = x_reg * x_reg;
    assign fine_cnt_inc   = fine_cnt_reg + 1'b1;
    assign block_cnt_inc  = block_cnt_reg + 1'b1;
    assign coarse_cnt_inc = coarse_cnt_reg + 1'b1;
    assign end_now        = end_reg || (block_cnt_inc >= BLOCK_CNT_W'(MAX_BLOCK_SAMPLES));

    always_comb begin
        case (level_reg)
            LEVEL_FINE: begin
                div_dividend = DIVD_W'(fine_sum_reg);
                div_divisor  = DIVS_W'(fine_cnt_reg);
            end
            LEVEL_COARSE: begin
                div_dividend = DIVD_W'(coarse_sum_reg);
                div_divisor  = m_reg;
            end
            default: begin
                div_dividend = DIVD_W'(block_sum_reg);
                div_divisor  = DIVS_W'(block_cnt_reg);
            end
        endcase
        if (state_reg == ST_SCALE_START) begin
            div_dividend = prod_reg;
            div_divisor  = DIVS_W'(fine_cnt_reg);
        end
    end

    always_comb begin
        out_result.level       = level_reg;
        out_result.rms_value   = rms_reg;
        out_result.min_value   = fine_min_reg;
        out_result.max_value   = fine_max_reg;
        out_result.last_of_run = !close_coarse_reg;
        case (level_reg)
            LEVEL_FINE: begin
                out_result.min_value   = fine_min_reg;
                out_result.max_value   = fine_max_reg;
                out_result.last_of_run = !close_coarse_reg;
            end
            LEVEL_COARSE: begin
                out_result.min_value   = coarse_min_reg;
                out_result.max_value   = coarse_max_reg;
                out_result.last_of_run = !end_reg;
            end
            default: begin
                out_result.min_value   = block_min_reg;
                out_result.max_value   = block_max_reg;
                out_result.last_of_run = 1'b1;
            end
        endcase
    end

    always_comb begin
        state_next        = state_reg;
        x_next            = x_reg;
        end_next          = end_reg;
        close_coarse_next = close_coarse_reg;
        level_next        = level_reg;
        sq_next           = sq_reg;
        rms_next          = rms_reg;
        prod_next         = prod_reg;
        m_next            = m_reg;
        fine_min_next     = fine_min_reg;
        fine_max_next     = fine_max_reg;
        fine_sum_next     = fine_sum_reg;
        fine_cnt_next     = fine_cnt_reg;
        coarse_min_next   = coarse_min_reg;
        coarse_max_next   = coarse_max_reg;
        coarse_sum_next   = coarse_sum_reg;
        coarse_cnt_next   = coarse_cnt_reg;
        block_min_next    = block_min_reg;
        block_max_next    = block_max_reg;
        block_sum_next    = block_sum_reg;
        block_cnt_next    = block_cnt_reg;
        s_tready          = 1'b0;
        div_start         = 1'b0;
        root_start        = 1'b0;
        out_load          = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    x_next     = x_in;
                    end_next   = s_tlast;
                    state_next = ST_SQUARE;
                end
            end
            ST_SQUARE: begin
                sq_next    = square[SQ_W-1:0];
                state_next = ST_ACCUM;
            end
            ST_ACCUM: begin
                if (fine_cnt_reg == '0) begin
                    fine_min_next = x_reg;
                    fine_max_next = x_reg;
                end else begin
                    if (x_reg < fine_min_reg) fine_min_next = x_reg;
                    if (x_reg > fine_max_reg) fine_max_next = x_reg;
                end
                fine_sum_next = fine_sum_reg + FINE_SUM_W'(sq_reg);
                fine_cnt_next = fine_cnt_inc;
                if (block_cnt_reg == '0) begin
                    block_min_next = x_reg;
                    block_max_next = x_reg;
                end else begin
                    if (x_reg < block_min_reg) block_min_next = x_reg;
                    if (x_reg > block_max_reg) block_max_next = x_reg;
                end
                block_sum_next    = block_sum_reg + BLOCK_SUM_W'(sq_reg);
                block_cnt_next    = block_cnt_inc;
                end_next          = end_now;
                close_coarse_next = end_now ||
                                    (coarse_cnt_inc >= COARSE_CNT_W'(FINES_PER_COARSE));
                if (end_now || (fine_cnt_inc >= FINE_CNT_W'(FINE_WINDOW))) begin
                    level_next = LEVEL_FINE;
                    state_next = ST_DIV_START;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_DIV_START: begin
                div_start  = 1'b1;
                state_next = ST_DIV_WAIT;
            end
            ST_DIV_WAIT: begin
                if (div_stat.done) begin
                    state_next = ST_ROOT_START;
                end
            end
            ST_ROOT_START: begin
                root_start = 1'b1;
                state_next = ST_ROOT_WAIT;
            end
            ST_ROOT_WAIT: begin
                if (root_stat.done) begin
                    rms_next   = root_value;
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_can_load) begin
                    out_load = 1'b1;
                    case (level_reg)
                        LEVEL_FINE: begin
                            state_next = ST_SCALE_MUL;
                        end
                        LEVEL_COARSE: begin
                            coarse_min_next = '0;
                            coarse_max_next = '0;
                            coarse_sum_next = '0;
                            coarse_cnt_next = '0;
                            if (end_reg) begin
                                level_next = LEVEL_BLOCK;
                                state_next = ST_DIV_START;
                            end else begin
                                state_next = ST_IDLE;
                            end
                        end
                        default: begin
                            block_min_next = '0;
                            block_max_next = '0;
                            block_sum_next = '0;
                            block_cnt_next = '0;
                            state_next     = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_SCALE_MUL: begin
                prod_next  = DIVD_W'(fine_sum_reg) * DIVD_W'(FINE_WINDOW);
                m_next     = DIVS_W'(coarse_cnt_reg) * DIVS_W'(FINE_WINDOW) +
                             DIVS_W'(fine_cnt_reg);
                state_next = ST_SCALE_START;
            end
            ST_SCALE_START: begin
                div_start  = 1'b1;
                state_next = ST_SCALE_WAIT;
            end
            ST_SCALE_WAIT: begin
                if (div_stat.done) begin
                    coarse_sum_next = coarse_sum_reg + COARSE_SUM_W'(div_quotient);
                    if (coarse_cnt_reg == '0) begin
                        coarse_min_next = fine_min_reg;
                        coarse_max_next = fine_max_reg;
                    end else begin
                        if (fine_min_reg < coarse_min_reg) coarse_min_next = fine_min_reg;
                        if (fine_max_reg > coarse_max_reg) coarse_max_next = fine_max_reg;
                    end
                    coarse_cnt_next = coarse_cnt_inc;
                    fine_min_next   = '0;
                    fine_max_next   = '0;
                    fine_sum_next   = '0;
                    fine_cnt_next   = '0;
                    if (close_coarse_reg) begin
                        level_next = LEVEL_COARSE;
                        state_next = ST_DIV_START;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            end_reg          <= 1'b0;
            close_coarse_reg <= 1'b0;
            level_reg        <= LEVEL_FINE;
            fine_min_reg     <= '0;
            fine_max_reg     <= '0;
            fine_sum_reg     <= '0;
            fine_cnt_reg     <= '0;
            coarse_min_reg   <= '0;
            coarse_max_reg   <= '0;
            coarse_sum_reg   <= '0;
            coarse_cnt_reg   <= '0;
            block_min_reg    <= '0;
            block_max_reg    <= '0;
            block_sum_reg    <= '0;
            block_cnt_reg    <= '0;
        end else begin
            state_reg        <= state_next;
            end_reg          <= end_next;
            close_coarse_reg <= close_coarse_next;
            level_reg        <= level_next;
            fine_min_reg     <= fine_min_next;
            fine_max_reg     <= fine_max_next;
            fine_sum_reg     <= fine_sum_next;
            fine_cnt_reg     <= fine_cnt_next;
            coarse_min_reg   <= coarse_min_next;
            coarse_max_reg   <= coarse_max_next;
            coarse_sum_reg   <= coarse_sum_next;
            coarse_cnt_reg   <= coarse_cnt_next;
            block_min_reg    <= block_min_next;
            block_max_reg    <= block_max_next;
            block_sum_reg    <= block_sum_next;
            block_cnt_reg    <= block_cnt_next;
        end
        x_reg    <= x_next;
        sq_reg   <= sq_next;
        rms_reg  <= rms_next;
        prod_reg <= prod_next;
        m_reg    <= m_next;
    end

    ammrs_divider u_divider (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .stat     (div_stat),
        .quotient (div_quotient)
    );

    ammrs_sqrt u_sqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (root_start),
        .radicand (div_quotient[RAD_W-1:0]),
        .stat     (root_stat),
        .root     (root_value)
    );

    ammrs_out_reg u_out_reg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (out_load),
        .result   (out_result),
        .can_load (out_can_load),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    `AMMRS_ASSERT_SAME(a_div_start_idle, aclk, aresetn, div_start, !div_stat.busy, "divider restarted while busy")
    `AMMRS_ASSERT_NEXT(a_accept_blocks, aclk, aresetn, s_tvalid && s_tready, !s_tready, "sample accepted while previous sample in progress")
    `AMMRS_ASSERT_NEXT(a_root_to_emit, aclk, aresetn, root_stat.done && (state_reg == ST_ROOT_WAIT), state_reg == ST_EMIT, "root result not moved to output stage")

endmodule

// ===== sv/ammrs_divider.sv =====
// Restoring divider that produces one quotient bit per cycle.
// Depends on ammrs_pkg for widths and the status struct.
module ammrs_divider (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [ammrs_pkg::DIVD_W-1:0]  dividend,
    input  logic [ammrs_pkg::DIVS_W-1:0]  divisor,
    output ammrs_pkg::unit_status_t       stat,
    output logic [ammrs_pkg::DIVD_W-1:0]  quotient
);
    import ammrs_pkg::*;

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [DIVS_W-1:0]    rem_reg, rem_next;
    logic [DIVD_W-1:0]    quo_reg, quo_next;
    logic [DIVS_W-1:0]    dsr_reg, dsr_next;
    logic [DIVS_W:0]      trial;
    logic [DIVS_W:0]      diff;

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        trial     = {rem_reg, quo_reg[DIVD_W-1]};
        diff      = trial - {1'b0, dsr_reg};
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = DIV_CNT_W'(DIVD_W - 1);
            rem_next  = '0;
            quo_next  = dividend;
            dsr_next  = divisor;
        end else if (busy_reg) begin
            if (trial >= {1'b0, dsr_reg}) begin
                rem_next = diff[DIVS_W-1:0];
                quo_next = {quo_reg[DIVD_W-2:0], 1'b1};
            end else begin
                rem_next = trial[DIVS_W-1:0];
                quo_next = {quo_reg[DIVD_W-2:0], 1'b0};
            end
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end else begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = quo_reg;

endmodule

// ===== sv/ammrs_sqrt.sv =====
// Floored integer square root that resolves one result bit per cycle.
// Depends on ammrs_pkg for widths and the status struct.
module ammrs_sqrt (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [ammrs_pkg::RAD_W-1:0]   radicand,
    output ammrs_pkg::unit_status_t       stat,
    output logic [ammrs_pkg::ROOT_W-1:0]  root
);
    import ammrs_pkg::*;

    localparam int REM_W = ROOT_FULL_W + 2;

    logic                   busy_reg, busy_next;
    logic                   done_reg, done_next;
    logic [ROOT_CNT_W-1:0]  cnt_reg, cnt_next;
    logic [RAD_W-1:0]       rad_reg, rad_next;
    logic [REM_W-1:0]       rem_reg, rem_next;
    logic [ROOT_FULL_W-1:0] root_reg, root_next;
    logic [REM_W+1:0]       trial_rem;
    logic [REM_W+1:0]       trial;
    logic [REM_W+1:0]       diff;

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rad_next  = rad_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        trial_rem = {rem_reg, rad_reg[RAD_W-1:RAD_W-2]};
        trial     = {2'b00, root_reg, 2'b01};
        diff      = trial_rem - trial;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = ROOT_CNT_W'(ROOT_FULL_W - 1);
            rad_next  = radicand;
            rem_next  = '0;
            root_next = '0;
        end else if (busy_reg) begin
            rad_next = {rad_reg[RAD_W-3:0], 2'b00};
            if (trial_rem >= trial) begin
                rem_next  = diff[REM_W-1:0];
                root_next = {root_reg[ROOT_FULL_W-2:0], 1'b1};
            end else begin
                rem_next  = trial_rem[REM_W-1:0];
                root_next = {root_reg[ROOT_FULL_W-2:0], 1'b0};
            end
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end else begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rad_reg  <= rad_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign root      = root_reg[ROOT_W-1:0];

endmodule

// ===== sv/ammrs_out_reg.sv =====
// Output register of the result stream, holding one result until it is taken.
// Depends on ammrs_pkg for the result struct.
module ammrs_out_reg (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          load,
    input  ammrs_pkg::result_t            result,
    output logic                          can_load,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [ammrs_pkg::DATA_W-1:0]  m_tdata,  // min_value, max_value, rms_value
    output logic [ammrs_pkg::LEVEL_W-1:0] m_tuser,  // level
    output logic                          m_tlast
);
    import ammrs_pkg::*;

    logic    valid_reg, valid_next;
    result_t data_reg;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        if (load) begin
            data_reg <= result;
        end
    end

    assign can_load = !valid_reg || m_tready;
    assign m_tvalid = valid_reg;
    assign m_tdata  = {data_reg.rms_value, data_reg.max_value, data_reg.min_value};
    assign m_tuser  = data_reg.level;
    assign m_tlast  = data_reg.last_of_run;

endmodule

// ===== tb/audio_min_max_rms_summary_checker.sv =====
// Checker for the audio min/max/RMS summary block: watches both stream channels,
// predicts fine, coarse and block summaries, and compares. Depends on ammrs_pkg.
`timescale 1ns / 1ps

module audio_min_max_rms_summary_checker #(
    parameter int FINE_WINDOW       = 256,
    parameter int COARSE_WINDOW     = 65536,
    parameter int MAX_BLOCK_SAMPLES = 1048576
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    input  logic [ammrs_pkg::SAMPLE_W-1:0] s_tdata,
    input  logic                           s_tlast,
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic [ammrs_pkg::DATA_W-1:0]   m_tdata,
    input  logic [ammrs_pkg::LEVEL_W-1:0]  m_tuser,
    input  logic                           m_tlast,
    output int                             fail_count,
    output int                             pending
);
    import ammrs_pkg::*;

    localparam int FINES_PER_COARSE = COARSE_WINDOW / FINE_WINDOW;

    result_t summary_q[$];

    logic signed [15:0] fine_lo, fine_hi, coarse_lo, coarse_hi, block_lo, block_hi;
    logic [63:0] fine_sq, coarse_msq, block_sq;
    int unsigned fine_n, coarse_n, block_n;

    initial fail_count = 0;
    initial pending = 0;

    function automatic logic [15:0] floor_root(input logic [63:0] v);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r[15:0];
    endfunction

    task automatic push_summary(input logic [1:0] lvl, input logic signed [15:0] lo,
                                input logic signed [15:0] hi, input logic [15:0] rms);
        result_t r;
        r.level = lvl;
        r.min_value = lo;
        r.max_value = hi;
        r.rms_value = rms;
        r.last_of_run = 1'b0;
        summary_q.push_back(r);
    endtask

    task automatic absorb_sample(input logic signed [15:0] x, input logic tail);
        logic [63:0] sq;
        logic [63:0] scaled;
        logic [63:0] span;
        logic closes;
        int first;
        first = summary_q.size();
        sq = 64'(signed'(32'(x) * 32'(x)));
        if (fine_n == 0) begin
            fine_lo = x;
            fine_hi = x;
        end else begin
            if (x < fine_lo) fine_lo = x;
            if (x > fine_hi) fine_hi = x;
        end
        fine_sq += sq;
        fine_n++;
        if (block_n == 0) begin
            block_lo = x;
            block_hi = x;
        end else begin
            if (x < block_lo) block_lo = x;
            if (x > block_hi) block_hi = x;
        end
        block_sq += sq;
        block_n++;
        closes = tail || (block_n >= MAX_BLOCK_SAMPLES);
        if (fine_n >= FINE_WINDOW || closes) begin
            scaled = fine_sq * FINE_WINDOW / fine_n;
            push_summary(LEVEL_FINE, fine_lo, fine_hi, floor_root(fine_sq / fine_n));
            if (coarse_n == 0) begin
                coarse_lo = fine_lo;
                coarse_hi = fine_hi;
            end else begin
                if (fine_lo < coarse_lo) coarse_lo = fine_lo;
                if (fine_hi > coarse_hi) coarse_hi = fine_hi;
            end
            coarse_msq += scaled;
            coarse_n++;
            if (coarse_n >= FINES_PER_COARSE || closes) begin
                span = 64'(coarse_n - 1) * FINE_WINDOW + fine_n;
                push_summary(LEVEL_COARSE, coarse_lo, coarse_hi,
                             floor_root(coarse_msq / span));
                coarse_lo = 0;
                coarse_hi = 0;
                coarse_msq = 0;
                coarse_n = 0;
            end
            fine_lo = 0;
            fine_hi = 0;
            fine_sq = 0;
            fine_n = 0;
        end
        if (closes) begin
            push_summary(LEVEL_BLOCK, block_lo, block_hi, floor_root(block_sq / block_n));
            block_lo = 0;
            block_hi = 0;
            block_sq = 0;
            block_n = 0;
        end
        if (summary_q.size() > first) summary_q[$].last_of_run = 1'b1;
    endtask

    always @(posedge aclk) begin
        result_t exp_r;
        if (!aresetn) begin
            fine_lo = 0; fine_hi = 0; fine_sq = 0; fine_n = 0;
            coarse_lo = 0; coarse_hi = 0; coarse_msq = 0; coarse_n = 0;
            block_lo = 0; block_hi = 0; block_sq = 0; block_n = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (summary_q.size() == 0) begin
                    $error("unexpected summary transaction: tuser=%0d tdata=%h",
                           m_tuser, m_tdata);
                    fail_count++;
                end else begin
                    exp_r = summary_q.pop_front();
                    if (m_tuser !== exp_r.level) begin
                        $error("level: expected %0d, actual %0d", exp_r.level, m_tuser);
                        fail_count++;
                    end
                    if (m_tdata[15:0] !== exp_r.min_value) begin
                        $error("min_value: expected %0d, actual %0d", exp_r.min_value,
                               $signed(m_tdata[15:0]));
                        fail_count++;
                    end
                    if (m_tdata[31:16] !== exp_r.max_value) begin
                        $error("max_value: expected %0d, actual %0d", exp_r.max_value,
                               $signed(m_tdata[31:16]));
                        fail_count++;
                    end
                    if (m_tdata[47:32] !== exp_r.rms_value) begin
                        $error("rms_value: expected %0d, actual %0d", exp_r.rms_value,
                               m_tdata[47:32]);
                        fail_count++;
                    end
                    if (m_tlast !== exp_r.last_of_run) begin
                        $error("last_of_run: expected %0d, actual %0d",
                               exp_r.last_of_run, m_tlast);
                        fail_count++;
                    end
                end
            end
            if (s_tvalid && s_tready) absorb_sample(s_tdata, s_tlast);
        end
        pending = summary_q.size();
    end
endmodule

// ===== tb/tb_audio_min_max_rms_summary.sv =====
// Testbench top: drives the audio min/max/RMS summary block with random sample gaps
// and back-pressure, gives the verdict. Depends on ammrs_pkg, the block, the checker.
`timescale 1ns / 1ps

module tb_audio_min_max_rms_summary;
    import ammrs_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [SAMPLE_W-1:0] s_tdata = '0;
    logic s_tlast = 1'b0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [DATA_W-1:0] m_tdata;
    logic [LEVEL_W-1:0] m_tuser;
    logic m_tlast;
    int fail_count;
    int pending;
    int cycle_count = 0;
    int hold_off = 0;
    bit calm = 1'b0;

    always #4 aclk = ~aclk;

    audio_min_max_rms_summary dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .m_tlast(m_tlast)
    );

    audio_min_max_rms_summary_checker monitor (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .m_tlast(m_tlast), .fail_count(fail_count), .pending(pending)
    );

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("audio_min_max_rms_summary verification failed");
            $finish;
        end
    end

    always @(negedge aclk) begin
        if (hold_off > 0) begin
            hold_off--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= calm || ($urandom_range(99) >= 6);
        end
    end

    task automatic send_sample(input logic [15:0] x, input logic tail);
        while (!calm && $urandom_range(99) < 6) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= x;
        s_tlast <= tail;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(negedge aclk);
        while (pending != 0) @(negedge aclk);
    endtask

    task automatic send_block(input int len, input int mode);
        logic [15:0] x;
        for (int i = 0; i < len; i++) begin
            case (mode)
                0: x = 16'($urandom);
                1: x = $urandom_range(1) ? 16'h7fff : 16'h8000;
                default: x = 16'($signed($urandom_range(64)) - 32);
            endcase
            send_sample(x, i == len - 1);
        end
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        send_sample(16'h8000, 1'b1);
        send_sample(16'h7fff, 1'b1);
        send_sample(16'h0000, 1'b1);
        send_sample(16'hffff, 1'b0);
        send_sample(16'h0001, 1'b0);
        send_sample(16'h8000, 1'b0);
        send_sample(16'h7fff, 1'b1);
        wait_drained();
        send_block(40, 1);
        send_block(33, 0);
        wait_drained();
        hold_off = 400;
        for (int b = 0; b < 4; b++) send_block(3, 0);
        wait_drained();
        calm = 1'b1;
        send_block(24, 2);
        calm = 1'b0;
        for (int b = 0; b < 6; b++) send_block($urandom_range(1, 4), $urandom_range(2));
        wait_drained();
        repeat (400) @(negedge aclk);
        wait_drained();
        if (fail_count == 0) begin
            $display("audio_min_max_rms_summary verification clean");
        end else begin
            $display("audio_min_max_rms_summary verification failed");
        end
        $finish;
    end
endmodule
